// ===== rtl/core/tmf_pkg.sv =====
// Shared constants, register codes and types for the thresholded 3x3 max filter.
package tmf_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int PORT_PIX_W = 16;
    localparam int DIM_W      = 13;
    localparam int THR_W      = 16;
    localparam int ROW_W      = 12;
    localparam int MAX_ROWS   = 4096;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = REG_IDX_W'(2);

    localparam logic [DIM_W-1:0] WIDTH_RESET     = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET    = DIM_W'(480);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(65535);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [THR_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic first;
        logic last_col;
        logic emit;
        logic flush;
    } col_ctl_t;

endpackage

// ===== rtl/core/thresholded_3x3_max_filter_unit.sv =====
// Top level of the thresholded 3x3 max filter: APB registers, line store front end, filter back end.
// Pixels enter in raster order, one transaction per clock when the output side keeps up. Each
// output pixel is the 3x3 neighbourhood maximum (borders replicated), capped at the centre pixel
// plus threshold, saturated at the pixel maximum. Output lags input by one row: source pixels of
// row 0 give nothing, and after the frame's last row the user sends image_width transactions with
// operation = 1 to drain the final row; a pixel sent while that drain is pending, or a flush sent
// outside it, is taken and dropped. The last column of each row yields two results and the first
// column none (a row one pixel wide yields one); the front end takes one transaction every cycle
// in which the result queue has room. A result passes the column stage register and then the
// result queue before it leaves. The two line buffers live in one RAM of MAX_WIDTH entries of
// two pixels, read one column ahead; it needs no clearing pass. Configuration must be written
// only while the block is idle; the block itself does not enforce it.
module thresholded_3x3_max_filter_unit #(
    parameter int MAX_WIDTH  = tmf_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [tmf_pkg::PORT_PIX_W-1:0]    s_pixel_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tmf_pkg::PORT_PIX_W-1:0]    m_pixel_out,
    output logic                              m_last_of_frame,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tmf_pkg::*;

    cfg_t                  cfg;
    logic                  in_fire;
    logic                  col_valid;
    col_ctl_t              col_ctl;
    logic [PIXEL_BITS-1:0] col_max, col_mid, out_pixel;
    logic                  in_room;

    assign s_ready = in_room;
    assign in_fire = s_valid && s_ready;

    tmf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .in_op     (s_operation),
        .in_pixel  (s_pixel_in[PIXEL_BITS-1:0]),
        .col_valid (col_valid),
        .col_ctl   (col_ctl),
        .col_max   (col_max),
        .col_mid   (col_mid)
    );

    tmf_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (cfg.threshold),
        .col_valid (col_valid),
        .col_ctl   (col_ctl),
        .col_max   (col_max),
        .col_mid   (col_mid),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_pixel (out_pixel),
        .out_last  (m_last_of_frame),
        .in_room   (in_room)
    );

    assign m_pixel_out = PORT_PIX_W'(out_pixel);

    a_col_from_transaction: assert property (@(posedge aclk) disable iff (!aresetn)
        col_valid |-> $past(s_valid && s_ready))
        else $error("column stage loaded without an input transaction");

    a_stall_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid || col_valid))
        else $error("input stalled with nothing pending");

    a_row_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_valid && col_ctl.last_col) |=> (!col_valid || col_ctl.first))
        else $error("column after a row end is not the first column");

endmodule

// ===== rtl/core/tmf_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
module tmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tmf_regs.sv =====
// APB configuration registers: image width, image height, threshold.
module tmf_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tmf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tmf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output tmf_pkg::cfg_t                     cfg
);
    import tmf_pkg::*;

    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [THR_W-1:0]     threshold_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg     <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg    <= pwdata[DIM_W-1:0];
                REG_THRESHOLD:    threshold_reg <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_THRESHOLD:    prdata = APB_DATA_W'(threshold_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.image_width  = width_reg;
    assign cfg.image_height = height_reg;
    assign cfg.threshold    = threshold_reg;

endmodule

// ===== rtl/core/tmf_front.sv =====
// Raster counters, line store read-modify-write with bypass, and column assembly.
module tmf_front #(
    parameter int MAX_WIDTH  = tmf_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tmf_pkg::cfg_t           cfg,
    input  logic                    in_fire,
    input  logic                    in_op,
    input  logic [PIXEL_BITS-1:0]   in_pixel,
    output logic                    col_valid,
    output tmf_pkg::col_ctl_t       col_ctl,
    output logic [PIXEL_BITS-1:0]   col_max,
    output logic [PIXEL_BITS-1:0]   col_mid
);
    import tmf_pkg::*;

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
    localparam int LINE_W = 2 * PIXEL_BITS;
    localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

    logic [CNT_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  draining_reg, draining_next;
    logic                  fwd_valid_reg;
    logic [LINE_W-1:0]     fwd_data_reg;
    logic                  col_valid_reg;
    col_ctl_t              col_ctl_reg;
    logic [PIXEL_BITS-1:0] col_max_reg, col_mid_reg;

    logic                  is_flush, take, row_zero, last_col, last_row;
    logic [LINE_W-1:0]     ram_rdata, line_q, ram_wdata;
    logic                  ram_we;
    logic [PIXEL_BITS-1:0] px_a, px_b, px_c, ab_max;
    col_ctl_t              ctl;

    function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    assign is_flush = (in_op == OP_FLUSH);
    assign take     = in_fire && (is_flush == draining_reg);
    assign row_zero = (row_reg == '0);
    assign last_col = ((CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(cfg.image_width)) ||
                      (col_reg == LAST_COL);
    assign last_row = ((DIM_W'(row_reg) + DIM_W'(1)) >= cfg.image_height) ||
                      (row_reg == LAST_ROW);

    // Low half holds the older row, high half the row just above the current one.
    assign line_q = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign px_a   = (!is_flush && row_zero) ? in_pixel : line_q[PIXEL_BITS-1:0];
    assign px_b   = (!is_flush && row_zero) ? in_pixel : line_q[LINE_W-1:PIXEL_BITS];
    assign px_c   = is_flush ? line_q[LINE_W-1:PIXEL_BITS] : in_pixel;
    assign ab_max = max2(px_a, px_b);

    assign ram_we    = take && !is_flush;
    assign ram_wdata = {in_pixel, px_b};

    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (take) begin
            if (last_col) begin
                col_next = '0;
                if (is_flush) begin
                    draining_next = 1'b0;
                    row_next      = '0;
                end else if (last_row) begin
                    draining_next = 1'b1;
                    row_next      = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end else begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        ctl.first    = (col_reg == '0);
        ctl.last_col = last_col;
        ctl.emit     = is_flush || !row_zero;
        ctl.flush    = is_flush;
    end

    // Read runs one column ahead; the bypass covers a write to the entry being fetched.
    tmf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (ram_wdata),
        .raddr (col_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            draining_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            col_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            draining_reg  <= draining_next;
            fwd_valid_reg <= ram_we && (col_reg == col_next);
            col_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wdata;
        if (take) begin
            col_ctl_reg <= ctl;
            col_max_reg <= max2(ab_max, px_c);
            col_mid_reg <= px_b;
        end
    end

    assign col_valid = col_valid_reg;
    assign col_ctl   = col_ctl_reg;
    assign col_max   = col_max_reg;
    assign col_mid   = col_mid_reg;

endmodule

// ===== rtl/core/tmf_back.sv =====
// Sliding window of column summaries, thresholded max, and the result queue.
module tmf_back #(
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tmf_pkg::THR_W-1:0]   threshold,
    input  logic                        col_valid,
    input  tmf_pkg::col_ctl_t           col_ctl,
    input  logic [PIXEL_BITS-1:0]       col_max,
    input  logic [PIXEL_BITS-1:0]       col_mid,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [PIXEL_BITS-1:0]       out_pixel,
    output logic                        out_last,
    output logic                        in_room
);
    import tmf_pkg::*;

    localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;

    logic [PIXEL_BITS-1:0] m_max_reg, r_max_reg, r_mid_reg;
    logic [PIXEL_BITS-1:0] q_pix_reg [QUEUE_DEPTH];
    logic                  q_last_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]     count_reg, count_next;

    logic [PIXEL_BITS-1:0] th_sat, res1, res2;
    logic                  v1, v2, pop;
    logic [QPTR_W-1:0]     wr_ptr2;
    logic [QCNT_W:0]       fill;

    function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] limit(input logic [PIXEL_BITS-1:0] mx,
                                                    input logic [PIXEL_BITS-1:0] centre,
                                                    input logic [PIXEL_BITS-1:0] th);
        logic [PIXEL_BITS:0]   sum;
        logic [PIXEL_BITS-1:0] lim;
        sum = {1'b0, centre} + {1'b0, th};
        lim = sum[PIXEL_BITS] ? '1 : sum[PIXEL_BITS-1:0];
        return (mx < lim) ? mx : lim;
    endfunction

    assign th_sat = (threshold > THR_W'(PIX_MAX)) ? '1 : threshold[PIXEL_BITS-1:0];

    assign res1 = limit(max2(max2(m_max_reg, r_max_reg), col_max), r_mid_reg, th_sat);
    assign res2 = limit(col_ctl.first ? col_max : max2(r_max_reg, col_max), col_mid, th_sat);

    assign v1 = col_valid && col_ctl.emit && !col_ctl.first;
    assign v2 = col_valid && col_ctl.emit && col_ctl.last_col;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign wr_ptr2   = wr_ptr_reg + QPTR_W'(v1);

    assign count_next = count_reg + QCNT_W'(v1) + QCNT_W'(v2) - QCNT_W'(pop);

    // Room for the pending column's results plus the two a new transaction may bring.
    assign fill    = (QCNT_W + 1)'(count_reg) + (QCNT_W + 1)'(v1) + (QCNT_W + 1)'(v2);
    assign in_room = (fill <= (QCNT_W + 1)'(QUEUE_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (col_valid) begin
            if (col_ctl.first || col_ctl.last_col) begin
                m_max_reg <= col_max;
            end else begin
                m_max_reg <= r_max_reg;
            end
            r_max_reg <= col_max;
            r_mid_reg <= col_mid;
        end
        if (v1) begin
            q_pix_reg[wr_ptr_reg]  <= res1;
            q_last_reg[wr_ptr_reg] <= 1'b0;
        end
        if (v2) begin
            q_pix_reg[wr_ptr2]  <= res2;
            q_last_reg[wr_ptr2] <= col_ctl.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(v1) + QPTR_W'(v2);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    assign out_pixel = q_pix_reg[rd_ptr_reg];
    assign out_last  = q_last_reg[rd_ptr_reg];

endmodule

// ===== tb/tmf_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the 3x3 max filter: follows register writes, predicts and compares output pixels.
module tmf_checker #(
    parameter int MAX_WIDTH  = tmf_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_operation,
    input  logic [tmf_pkg::PORT_PIX_W-1:0]    s_pixel_in,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [tmf_pkg::PORT_PIX_W-1:0]    m_pixel_out,
    input  logic                              m_last_of_frame,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tmf_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic                              pready,
    output int                                mismatch_count,
    output int                                pending_results
);
    import tmf_pkg::*;

    localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;

    typedef struct packed {
        logic [PORT_PIX_W-1:0] pixel;
        logic                  last;
    } filtered_pixel_t;

    filtered_pixel_t       expected_pixels[$];

    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [THR_W-1:0]      threshold_reg;

    logic [PORT_PIX_W-1:0] line_mem [2*MAX_WIDTH];
    logic [PORT_PIX_W-1:0] win [9];
    int unsigned           col_pos;
    int unsigned           row_pos;
    bit                    draining;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PORT_PIX_W-1:0] capped_max();
        int unsigned mx;
        int unsigned th;
        int unsigned lim;
        mx = 0;
        th = (threshold_reg > PIX_MAX) ? PIX_MAX : threshold_reg;
        lim = win[4] + th;
        for (int i = 0; i < 9; i++) begin
            if (win[i] > mx) mx = win[i];
        end
        if (lim > PIX_MAX) lim = PIX_MAX;
        return PORT_PIX_W'((mx < lim) ? mx : lim);
    endfunction

    task automatic shift_column(input logic [PORT_PIX_W-1:0] c0, c1, c2);
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = c0;
        win[5] = c1;
        win[8] = c2;
    endtask

    task automatic predict_dilation(input logic op, input logic [PORT_PIX_W-1:0] px_raw);
        int unsigned           w;
        int unsigned           h;
        int unsigned           c;
        logic [PORT_PIX_W-1:0] px;
        logic [PORT_PIX_W-1:0] c0;
        logic [PORT_PIX_W-1:0] c1;
        logic [PORT_PIX_W-1:0] c2;
        bit                    emit;
        bit                    lastcol;
        px = px_raw & PORT_PIX_W'(PIX_MAX);
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_ROWS);
        if ((op == OP_PIXEL && draining) || (op == OP_FLUSH && !draining)) return;
        c = col_pos;
        if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
        lastcol = (c >= w - 1);
        c0 = line_mem[c];
        c1 = line_mem[MAX_WIDTH + c];
        if (op == OP_PIXEL) begin
            c2 = px;
            if (row_pos == 0) begin
                c0 = px;
                c1 = px;
            end
            line_mem[c] = c1;
            line_mem[MAX_WIDTH + c] = px;
            emit = (row_pos >= 1);
        end else begin
            c2 = c1;
            emit = 1'b1;
        end

        if (c == 0) begin
            for (int k = 0; k < 3; k++) begin
                win[k]     = c0;
                win[3 + k] = c1;
                win[6 + k] = c2;
            end
        end else begin
            shift_column(c0, c1, c2);
            if (emit) expected_pixels.push_back('{pixel: capped_max(), last: 1'b0});
        end

        if (lastcol) begin
            if (c >= 1) shift_column(c0, c1, c2);
            if (emit) expected_pixels.push_back('{pixel: capped_max(), last: (op == OP_FLUSH)});
            col_pos = 0;
            if (op == OP_FLUSH) begin
                draining = 1'b0;
                row_pos = 0;
            end else if (row_pos >= h - 1) begin
                draining = 1'b1;
                row_pos = 0;
            end else begin
                row_pos++;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge aclk) begin : monitor
        filtered_pixel_t       want;
        logic [REG_IDX_W-1:0]  reg_idx;
        if (!aresetn) begin
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            threshold_reg = THRESHOLD_RESET;
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (win[i]) win[i] = '0;
            col_pos = 0;
            row_pos = 0;
            draining = 1'b0;
            expected_pixels.delete();
            mismatch_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                reg_idx = paddr[APB_ADDR_W-1:2];
                case (reg_idx)
                    REG_IMAGE_WIDTH:  width_reg = pwdata[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg = pwdata[DIM_W-1:0];
                    REG_THRESHOLD:    threshold_reg = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected output transaction: pixel_out %0d, last_of_frame %0d",
                           m_pixel_out, m_last_of_frame);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_pixel_out !== want.pixel) begin
                        $error("pixel_out mismatch: expected %0d, actual %0d",
                               want.pixel, m_pixel_out);
                        mismatch_count++;
                    end
                    if (m_last_of_frame !== want.last) begin
                        $error("last_of_frame mismatch: expected %0d, actual %0d",
                               want.last, m_last_of_frame);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_dilation(s_operation, s_pixel_in);
        end
        pending_results = expected_pixels.size();
    end

endmodule

// ===== tb/tb_thresholded_3x3_max_filter_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the thresholded 3x3 max filter: stimulus, register setup and verdict.
module tb_thresholded_3x3_max_filter_unit;
    import tmf_pkg::*;

    localparam int TB_MAX_WIDTH  = DEF_MAX_WIDTH;
    localparam int TB_PIXEL_BITS = DEF_PIXEL_BITS;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int ITEM_TARGET   = 1550;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = OP_PIXEL;
    logic [PORT_PIX_W-1:0] s_pixel_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PORT_PIX_W-1:0] m_pixel_out;
    logic                  m_last_of_frame;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatch_count;
    int                    pending_results;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    ready_run = 0;
    int                    ready_stall = 0;
    int                    cur_w;
    int                    cur_h;

    thresholded_3x3_max_filter_unit #(
        .MAX_WIDTH  (TB_MAX_WIDTH),
        .PIXEL_BITS (TB_PIXEL_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_last_of_frame (m_last_of_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    tmf_checker #(
        .MAX_WIDTH  (TB_MAX_WIDTH),
        .PIXEL_BITS (TB_PIXEL_BITS)
    ) result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_pixel_in      (s_pixel_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_out     (m_pixel_out),
        .m_last_of_frame (m_last_of_frame),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side backpressure: long open stretches or short run/stall bursts
    always @(negedge aclk) begin
        if (ready_run > 0) begin
            m_ready <= 1'b1;
            ready_run--;
        end else if (ready_stall > 0) begin
            m_ready <= 1'b0;
            ready_stall--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                ready_run = $urandom_range(50, 300);
                ready_stall = 0;
            end else begin
                ready_run = $urandom_range(0, 11);
                ready_stall = $urandom_range(1, 6);
            end
        end
    end

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [PORT_PIX_W-1:0] rand_pixel();
        logic [PORT_PIX_W-1:0] v;
        v = PORT_PIX_W'($urandom);
        case ($urandom_range(0, 5))
            0: v[7:0] = 8'h00;
            1: v[7:0] = 8'hFF;
            2: v[7:0] = 8'($urandom_range(240, 255));
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input int w, input int h, input int t);
        write_reg(REG_IMAGE_WIDTH, APB_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, APB_DATA_W'(h));
        write_reg(REG_THRESHOLD, APB_DATA_W'(t));
        cur_w = clamp_dim(w & 13'h1FFF, TB_MAX_WIDTH);
        cur_h = clamp_dim(h & 13'h1FFF, MAX_ROWS);
    endtask

    task automatic send_item(input logic op, input logic [PORT_PIX_W-1:0] px);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_pixel_in <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    // drop valid and wait until every predicted result has left the block
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic send_rows(input int fw, input int nrows);
        for (int r = 0; r < nrows; r++) begin
            for (int c = 0; c < fw; c++) send_item(OP_PIXEL, rand_pixel());
        end
    endtask

    task automatic send_flush_row(input int fw, input bit stray_pixel);
        int k;
        k = $urandom_range(0, fw - 1);
        for (int c = 0; c < fw; c++) begin
            if (stray_pixel && c == k) send_item(OP_PIXEL, rand_pixel());
            send_item(OP_FLUSH, PORT_PIX_W'($urandom));
        end
    endtask

    task automatic send_frame(input int fw, input int fh, input bit noisy);
        if (noisy && $urandom_range(0, 7) == 0) send_item(OP_FLUSH, PORT_PIX_W'($urandom));
        send_rows(fw, fh);
        send_flush_row(fw, noisy && $urandom_range(0, 7) == 0);
    endtask

    initial begin : stimulus
        logic [PORT_PIX_W-1:0] corner_px [9];
        int                    w;
        int                    h;
        int                    t;
        int                    counted;
        corner_px = '{16'h0000, 16'h00FF, 16'hFFFF, 16'h0100, 16'h0080,
                      16'hFF00, 16'h0001, 16'h00FE, 16'h0000};
        counted = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero threshold: output equals the center pixel
        configure(3, 3, 0);
        send_item(OP_FLUSH, 16'hFFFF);
        foreach (corner_px[i]) send_item(OP_PIXEL, corner_px[i]);
        send_item(OP_PIXEL, 16'h00FF);
        send_flush_row(3, 1'b0);

        settle();
        configure(1, 2, 300);
        send_item(OP_PIXEL, 16'h00FF);
        send_item(OP_PIXEL, 16'hFF00);
        send_item(OP_FLUSH, 16'h0000);

        settle();
        configure(0, 0, 16);
        send_frame(cur_w, cur_h, 1'b0);

        // registers rewritten between rows of one frame
        settle();
        configure(6, 4, 40);
        send_rows(6, 2);
        settle();
        configure(4, 3, 5);
        send_rows(4, 1);
        send_flush_row(4, 1'b0);

        while (counted < ITEM_TARGET) begin
            settle();
            case ($urandom_range(0, 19))
                0:          w = 0;
                1:          w = $urandom_range(41, 200);
                2, 3, 4, 5: w = $urandom_range(9, 40);
                default:    w = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = 0;
                1:       h = $urandom_range(7, 12);
                default: h = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 5))
                0:       t = 0;
                1:       t = 255;
                2:       t = 65535;
                3:       t = $urandom_range(1, 254);
                4:       t = $urandom_range(256, 65535);
                default: t = $urandom_range(0, 15);
            endcase
            configure(w, h, t);
            repeat ($urandom_range(1, 4)) begin
                send_frame(cur_w, cur_h, 1'b1);
                counted += cur_w * cur_h + cur_w;
            end
        end

        settle();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
